// File: hdl/mini_format_engine_s_d_x_macros.svh
// ============================================================================
// Assertion macros for the formatted-print engine
// Clocked implication checks, reset-qualified on arst_n.
// ============================================================================
`ifndef MINI_FORMAT_ENGINE_S_D_X_MACROS_SVH
`define MINI_FORMAT_ENGINE_S_D_X_MACROS_SVH

// same-cycle implication
`define MFE_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define MFE_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: hdl/mfe_pkg.sv
// ============================================================================
// mfe_pkg
// Types, codes and character helpers shared by the print engine modules.
// ============================================================================
package mfe_pkg;

	// item kinds on the input channel
	localparam logic [1:0] OP_FMT  = 2'd0;
	localparam logic [1:0] OP_WORD = 2'd1;
	localparam logic [1:0] OP_STR  = 2'd2;
	localparam logic [1:0] OP_NULL = 2'd3;

	// characters
	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_PCT   = 8'h25;
	localparam logic [7:0] CH_S     = 8'h73;
	localparam logic [7:0] CH_D     = 8'h64;
	localparam logic [7:0] CH_X     = 8'h78;
	localparam logic [7:0] CH_MINUS = 8'h2d;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_A     = 8'h61;

	localparam int CMD_DEPTH_DEF = 4;
	localparam int OUT_DEPTH_DEF = 2;

	typedef struct packed {
		logic [1:0]  operation;
		logic [7:0]  data_byte;
		logic [31:0] argument_word;
	} in_item_t;

	typedef struct packed {
		logic [7:0]  out_byte;
		logic        last;
		logic [31:0] byte_count;
	} out_item_t;

	typedef enum logic [2:0] {
		CMD_ECHO,
		CMD_DEC,
		CMD_HEX,
		CMD_NULL,
		CMD_CLEAR
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t   kind;
		logic [7:0]  data_byte;
		logic [31:0] argument_word;
	} cmd_t;

	// digit value to lower-case ASCII
	function automatic logic [7:0] digit_char(input logic [3:0] d);
		logic [7:0] c;
		if (d < 4'd10) begin
			c = CH_ZERO + {4'd0, d};
		end else begin
			c = CH_A + {4'd0, d} - 8'd10;
		end
		return c;
	endfunction

	// the text printed for a null string
	function automatic logic [7:0] null_char(input logic [2:0] i);
		logic [7:0] c;
		case (i)
			3'd0: c = 8'h28; // (
			3'd1: c = 8'h6e; // n
			3'd2: c = 8'h75; // u
			3'd3: c = 8'h6c; // l
			3'd4: c = 8'h6c; // l
			3'd5: c = 8'h29; // )
			default: c = 8'h3f;
		endcase
		return c;
	endfunction

endpackage

// File: hdl/mfe_fifo.sv
// ============================================================================
// mfe_fifo
// Small register queue with combinational read of the head entry.
// ============================================================================
module mfe_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr_en,
	input  logic [WIDTH-1:0] wr_data,
	output logic             full,
	input  logic             rd_en,
	output logic [WIDTH-1:0] rd_data,
	output logic             empty
);
	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [PW-1:0] PTR_LAST = PW'(DEPTH - 1);
	localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PW-1:0]    wr_ptr_q, rd_ptr_q;
	logic [CW-1:0]    cnt_q;
	logic             do_wr, do_rd;

	assign full    = (cnt_q == CNT_FULL);
	assign empty   = (cnt_q == '0);
	assign do_wr   = wr_en && !full;
	assign do_rd   = rd_en && !empty;
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

// File: hdl/mfe_front.sv
// ============================================================================
// mfe_front
// Format parser: tracks the conversion phase and turns items into commands.
// ============================================================================
module mfe_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  mfe_pkg::in_item_t item,
	input  logic              cmd_full,
	output logic              cmd_push,
	output mfe_pkg::cmd_t     cmd
);
	import mfe_pkg::*;

	typedef enum logic [2:0] {
		P_TEXT,
		P_PCT,
		P_DEC,
		P_HEX,
		P_STR
	} phase_t;

	phase_t phase_q, phase_d;
	logic   take, gen;

	assign take = push && !cmd_full;
	assign cmd_push = take && gen;

	always_comb begin
		phase_d            = phase_q;
		gen                = 1'b0;
		cmd.kind           = CMD_ECHO;
		cmd.data_byte      = item.data_byte;
		cmd.argument_word  = item.argument_word;
		case (phase_q)
			P_PCT: begin
				if (item.operation == OP_FMT) begin
					if (item.data_byte == CH_NUL) begin
						gen      = 1'b1;
						cmd.kind = CMD_CLEAR;
						phase_d  = P_TEXT;
					end else if (item.data_byte == CH_S) begin
						phase_d = P_STR;
					end else if (item.data_byte == CH_D) begin
						phase_d = P_DEC;
					end else if (item.data_byte == CH_X) begin
						phase_d = P_HEX;
					end else begin
						phase_d = P_TEXT;
					end
				end
			end
			P_DEC: begin
				if (item.operation == OP_WORD) begin
					gen      = 1'b1;
					cmd.kind = CMD_DEC;
					phase_d  = P_TEXT;
				end
			end
			P_HEX: begin
				if (item.operation == OP_WORD) begin
					gen      = 1'b1;
					cmd.kind = CMD_HEX;
					phase_d  = P_TEXT;
				end
			end
			P_STR: begin
				if (item.operation == OP_STR) begin
					if (item.data_byte == CH_NUL) begin
						phase_d = P_TEXT;
					end else begin
						gen = 1'b1;
					end
				end else if (item.operation == OP_NULL) begin
					gen      = 1'b1;
					cmd.kind = CMD_NULL;
					phase_d  = P_TEXT;
				end
			end
			default: begin
				phase_d = P_TEXT;
				if (item.operation == OP_FMT) begin
					if (item.data_byte == CH_NUL) begin
						gen      = 1'b1;
						cmd.kind = CMD_CLEAR;
					end else if (item.data_byte == CH_PCT) begin
						phase_d = P_PCT;
					end else begin
						gen = 1'b1;
					end
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= P_TEXT;
		end else if (take) begin
			phase_q <= phase_d;
		end
	end

endmodule

// File: hdl/mfe_back.sv
// ============================================================================
// mfe_back
// Print engine: runs commands, converts numbers and emits counted bytes.
// ============================================================================
`include "mini_format_engine_s_d_x_macros.svh"

module mfe_back (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cmd_empty,
	input  mfe_pkg::cmd_t      cmd,
	output logic               cmd_pop,
	input  logic               out_full,
	output logic               out_push,
	output mfe_pkg::out_item_t out_item
);
	import mfe_pkg::*;

	typedef enum logic [2:0] {
		B_IDLE,
		B_CONV,
		B_SIGN,
		B_DEC,
		B_HEX,
		B_NULL
	} mode_t;

	mode_t       mode_q;
	logic [31:0] total_q;
	logic [31:0] bin_q;
	logic [39:0] bcd_q;
	logic [2:0]  cnt_q;
	logic [3:0]  idx_q;
	logic        neg_q;

	logic [31:0] mag;
	logic [39:0] bcd_d;
	logic [31:0] bin_d;
	logic [3:0]  dec_lead;
	logic [2:0]  hex_lead;
	logic [7:0]  emit_byte;
	logic        emit_last;

	assign mag = cmd.argument_word[31] ? (32'd0 - cmd.argument_word) : cmd.argument_word;

	// four double-dabble steps per cycle
	always_comb begin
		logic [39:0] b;
		logic [31:0] s;
		b = bcd_q;
		s = bin_q;
		for (int st = 0; st < 4; st++) begin
			for (int d = 0; d < 10; d++) begin
				if (b[d*4 +: 4] >= 4'd5) begin
					b[d*4 +: 4] = b[d*4 +: 4] + 4'd3;
				end
			end
			b = {b[38:0], s[31]};
			s = {s[30:0], 1'b0};
		end
		bcd_d = b;
		bin_d = s;
	end

	// highest nonzero digit positions
	always_comb begin
		dec_lead = '0;
		for (int d = 0; d < 10; d++) begin
			if (bcd_q[d*4 +: 4] != 4'd0) begin
				dec_lead = 4'(d);
			end
		end
		hex_lead = '0;
		for (int h = 0; h < 8; h++) begin
			if (cmd.argument_word[h*4 +: 4] != 4'd0) begin
				hex_lead = 3'(h);
			end
		end
	end

	always_comb begin
		cmd_pop   = 1'b0;
		out_push  = 1'b0;
		emit_byte = cmd.data_byte;
		emit_last = 1'b0;
		case (mode_q)
			B_IDLE: begin
				if (!cmd_empty) begin
					if (cmd.kind == CMD_ECHO) begin
						cmd_pop   = !out_full;
						out_push  = !out_full;
						emit_last = 1'b1;
					end else begin
						cmd_pop = 1'b1;
					end
				end
			end
			B_SIGN: begin
				emit_byte = CH_MINUS;
				out_push  = neg_q && !out_full;
			end
			B_DEC: begin
				emit_byte = digit_char(bcd_q[{idx_q, 2'b00} +: 4]);
				emit_last = (idx_q == 4'd0);
				out_push  = !out_full;
			end
			B_HEX: begin
				emit_byte = digit_char(bin_q[{idx_q[2:0], 2'b00} +: 4]);
				emit_last = (idx_q == 4'd0);
				out_push  = !out_full;
			end
			B_NULL: begin
				emit_byte = null_char(idx_q[2:0]);
				emit_last = (idx_q == 4'd5);
				out_push  = !out_full;
			end
			default: begin
			end
		endcase
	end

	assign out_item.out_byte   = emit_byte;
	assign out_item.last       = emit_last;
	assign out_item.byte_count = total_q + 32'd1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= B_IDLE;
			total_q <= '0;
			bin_q   <= '0;
			bcd_q   <= '0;
			cnt_q   <= '0;
			idx_q   <= '0;
			neg_q   <= 1'b0;
		end else begin
			if (out_push) begin
				total_q <= total_q + 32'd1;
			end
			case (mode_q)
				B_IDLE: begin
					if (cmd_pop) begin
						case (cmd.kind)
							CMD_CLEAR: total_q <= '0;
							CMD_DEC: begin
								mode_q <= B_CONV;
								bin_q  <= mag;
								bcd_q  <= '0;
								cnt_q  <= 3'd7;
								neg_q  <= cmd.argument_word[31];
							end
							CMD_HEX: begin
								mode_q <= B_HEX;
								bin_q  <= cmd.argument_word;
								idx_q  <= {1'b0, hex_lead};
							end
							CMD_NULL: begin
								mode_q <= B_NULL;
								idx_q  <= '0;
							end
							default: begin
							end
						endcase
					end
				end
				B_CONV: begin
					bcd_q <= bcd_d;
					bin_q <= bin_d;
					cnt_q <= cnt_q - 3'd1;
					if (cnt_q == 3'd0) begin
						mode_q <= B_SIGN;
					end
				end
				B_SIGN: begin
					if (!neg_q || !out_full) begin
						mode_q <= B_DEC;
						idx_q  <= dec_lead;
					end
				end
				B_DEC, B_HEX: begin
					if (out_push) begin
						idx_q <= idx_q - 4'd1;
						if (idx_q == 4'd0) begin
							mode_q <= B_IDLE;
						end
					end
				end
				B_NULL: begin
					if (out_push) begin
						idx_q <= idx_q + 4'd1;
						if (idx_q == 4'd5) begin
							mode_q <= B_IDLE;
						end
					end
				end
				default: mode_q <= B_IDLE;
			endcase
		end
	end

	`MFE_ASSERT_IMP(a_push_room, out_push, !out_full, "result written into a full queue")
	`MFE_ASSERT_IMP(a_pop_valid, cmd_pop, !cmd_empty, "command taken from an empty queue")
	`MFE_ASSERT_IMP(a_conv_quiet, mode_q == B_CONV, !out_push && !cmd_pop, "activity while converting")
	`MFE_ASSERT_NXT(a_conv_end, (mode_q == B_CONV) && (cnt_q == 3'd0), mode_q == B_SIGN, "conversion did not finish in eight cycles")

endmodule

// File: hdl/mini_format_engine_s_d_x.sv
// ============================================================================
// mini_format_engine_s_d_x
// Formatted-print engine for %s, %d and %x with a running byte count.
// ============================================================================
//
//  channel | handshake       | payload            | transfer when
//  --------+-----------------+--------------------+---------------------
//  input   | push / full     | item   (in_item_t) | push && !full
//  result  | empty / pop     | result (out_item_t)| pop && !empty
//
//  The parser takes one item per cycle while the command queue has room;
//  items that only move the format phase or are ignored still need a slot free.
//  Back end: a plain byte is emitted straight from idle; "(null)" emits its six
//  bytes in turn; hex emits up to 8 digits; decimal runs the converter (4 bits
//  per cycle), then the sign state, then up to 10 digits, the longest command.
//  arst_n clears phase, byte count and both queues; no result pends after it.
//  A stalled result side fills the result queue, then the command queue,
//  then raises full; nothing is dropped.
//
module mini_format_engine_s_d_x #(
	parameter int CMD_DEPTH = mfe_pkg::CMD_DEPTH_DEF,
	parameter int OUT_DEPTH = mfe_pkg::OUT_DEPTH_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	output logic               full,
	input  mfe_pkg::in_item_t  item,
	output logic               empty,
	input  logic               pop,
	output mfe_pkg::out_item_t result
);
	import mfe_pkg::*;

	localparam int CMD_W = $bits(cmd_t);
	localparam int OUT_W = $bits(out_item_t);

	// parser -> command queue
	logic       cmd_push;
	cmd_t       cmd_in;
	logic       cmd_full;

	// command queue -> print engine
	logic [CMD_W-1:0] cmd_raw;
	cmd_t       cmd_head;
	logic       cmd_empty;
	logic       cmd_pop;

	// print engine -> result queue
	logic       out_push;
	out_item_t  out_item;
	logic       out_full;
	logic [OUT_W-1:0] out_raw;

	assign full     = cmd_full;
	assign cmd_head = cmd_t'(cmd_raw);
	assign result   = out_item_t'(out_raw);

	mfe_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.item     (item),
		.cmd_full (cmd_full),
		.cmd_push (cmd_push),
		.cmd      (cmd_in)
	);

	mfe_fifo #(
		.WIDTH (CMD_W),
		.DEPTH (CMD_DEPTH)
	) u_cmd_q (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (cmd_push),
		.wr_data (cmd_in),
		.full    (cmd_full),
		.rd_en   (cmd_pop),
		.rd_data (cmd_raw),
		.empty   (cmd_empty)
	);

	mfe_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_empty (cmd_empty),
		.cmd       (cmd_head),
		.cmd_pop   (cmd_pop),
		.out_full  (out_full),
		.out_push  (out_push),
		.out_item  (out_item)
	);

	// result queue decouples the engine from a stalled consumer
	mfe_fifo #(
		.WIDTH (OUT_W),
		.DEPTH (OUT_DEPTH)
	) u_out_q (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (out_push),
		.wr_data (out_item),
		.full    (out_full),
		.rd_en   (pop),
		.rd_data (out_raw),
		.empty   (empty)
	);

endmodule
